### hw/rtl/gdp_pkg.sv
`timescale 1ns / 1ps

package gdp_pkg;

	// Input func codes
	typedef enum logic [1:0] {
		FUNC_MAP_WRITE   = 2'd0,
		FUNC_SEARCH      = 2'd1,
		FUNC_PATH_READ   = 2'd2,
		FUNC_UNUSED      = 2'd3
	} func_t;

	// Reply kinds
	typedef enum logic [1:0] {
		REPLY_FOUND      = 2'd0,
		REPLY_UNREACH    = 2'd1,
		REPLY_PATH_CELL  = 2'd2,
		REPLY_EXHAUSTED  = 2'd3
	} reply_t;

	localparam logic [15:0] COST_UNREACHED = 16'hFFFF;
	localparam logic [15:0] COST_MAX       = 16'hFFFE;
	localparam logic [15:0] STEP_STRAIGHT  = 16'd10;
	localparam logic [15:0] STEP_DIAGONAL  = 16'd14;
	localparam int          NUM_DIRS       = 8;

	// Coordinate change of one neighbor step
	typedef enum logic [1:0] {
		D_ZERO = 2'd0,
		D_INC  = 2'd1,
		D_DEC  = 2'd2
	} delta_t;

	typedef struct packed {
		delta_t dx;
		delta_t dy;
	} step_t;

	// Memory read address source
	typedef enum logic [1:0] {
		RD_NBR   = 2'd0,
		RD_SCAN  = 2'd1,
		RD_PAR   = 2'd2,
		RD_PCOST = 2'd3
	} rd_sel_t;

	// Result to stage
	typedef enum logic [2:0] {
		RES_NONE      = 3'd0,
		RES_FOUND     = 3'd1,
		RES_UNREACH   = 3'd2,
		RES_PATH_CELL = 3'd3,
		RES_EXHAUSTED = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     cnt_clr;
		logic     cnt_step;
		logic     wipe_wr;
		logic     map_wr;
		logic     clr_wr;
		logic     init_start;
		logic     close_wr;
		logic     dir_rst;
		logic     dir_step;
		logic     relax_wr;
		logic     scan_init;
		logic     scan_step;
		logic     pick;
		logic     par_latch;
		rd_sel_t  rd_sel;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic search_ok;
		logic cur_is_goal;
		logic nbr_ok;
		logic dir_last;
		logic scan_last;
		logic found;
		logic path_ready;
		logic out_free;
	} sts_t;

	// Neighbor order: E, SE, S, SW, W, NW, N, NE
	function automatic step_t nbr_step(input logic [2:0] dir);
		step_t s;
		case (dir)
			3'd0: s = '{dx: D_INC,  dy: D_ZERO};
			3'd1: s = '{dx: D_INC,  dy: D_INC};
			3'd2: s = '{dx: D_ZERO, dy: D_INC};
			3'd3: s = '{dx: D_DEC,  dy: D_INC};
			3'd4: s = '{dx: D_DEC,  dy: D_ZERO};
			3'd5: s = '{dx: D_DEC,  dy: D_DEC};
			3'd6: s = '{dx: D_ZERO, dy: D_DEC};
			3'd7: s = '{dx: D_INC,  dy: D_DEC};
			default: s = '{dx: D_ZERO, dy: D_ZERO};
		endcase
		return s;
	endfunction

endpackage

### hw/rtl/gdp_ctrl.sv
`timescale 1ns / 1ps

module gdp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	input  logic [1:0]          s_axis_tuser,
	output logic                s_axis_tready,
	input  gdp_pkg::sts_t       sts,
	output gdp_pkg::cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_WIPE, ST_IDLE, ST_MAPW, ST_CLR, ST_CHK, ST_CLOSE, ST_NRD, ST_NWR,
		ST_SINIT, ST_SCAN, ST_SDRAIN, ST_SPICK, ST_PRD0, ST_PRD1, ST_PRD2, ST_RES
	} state_t;

	state_t state_q;

	assign s_axis_tready = (state_q == ST_IDLE);

	// Command decode
	always_comb begin
		cmd = '0;
		cmd.rd_sel = gdp_pkg::RD_NBR;
		cmd.res_sel = gdp_pkg::RES_NONE;
		case (state_q)
			ST_WIPE: begin
				cmd.wipe_wr = 1'b1;
				cmd.cnt_step = 1'b1;
			end
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load_in = 1'b1;
					cmd.cnt_clr = 1'b1;
				end
			end
			ST_MAPW: cmd.map_wr = 1'b1;
			ST_CLR: begin
				cmd.clr_wr = 1'b1;
				cmd.cnt_step = 1'b1;
			end
			ST_CHK: begin
				if (sts.search_ok) cmd.init_start = 1'b1;
				else cmd.res_sel = gdp_pkg::RES_UNREACH;
			end
			ST_CLOSE: begin
				cmd.close_wr = 1'b1;
				if (sts.cur_is_goal) cmd.res_sel = gdp_pkg::RES_FOUND;
				else cmd.dir_rst = 1'b1;
			end
			ST_NRD: begin
				cmd.rd_sel = gdp_pkg::RD_NBR;
				if (!sts.nbr_ok) cmd.dir_step = 1'b1;
			end
			ST_NWR: begin
				cmd.relax_wr = 1'b1;
				cmd.dir_step = 1'b1;
			end
			ST_SINIT: cmd.scan_init = 1'b1;
			ST_SCAN: begin
				cmd.rd_sel = gdp_pkg::RD_SCAN;
				cmd.scan_step = 1'b1;
			end
			ST_SDRAIN: cmd.rd_sel = gdp_pkg::RD_SCAN;
			ST_SPICK: begin
				if (sts.found) cmd.pick = 1'b1;
				else cmd.res_sel = gdp_pkg::RES_UNREACH;
			end
			ST_PRD0: begin
				if (sts.path_ready) cmd.rd_sel = gdp_pkg::RD_PAR;
				else cmd.res_sel = gdp_pkg::RES_EXHAUSTED;
			end
			ST_PRD1: begin
				cmd.rd_sel = gdp_pkg::RD_PCOST;
				cmd.par_latch = 1'b1;
			end
			ST_PRD2: cmd.res_sel = gdp_pkg::RES_PATH_CELL;
			ST_RES: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			case (state_q)
				ST_WIPE: if (sts.cnt_last) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						case (s_axis_tuser)
							gdp_pkg::FUNC_MAP_WRITE: state_q <= ST_MAPW;
							gdp_pkg::FUNC_SEARCH:    state_q <= ST_CLR;
							gdp_pkg::FUNC_PATH_READ: state_q <= ST_PRD0;
							default:                 state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MAPW: state_q <= ST_IDLE;
				ST_CLR: if (sts.cnt_last) state_q <= ST_CHK;
				ST_CHK: state_q <= sts.search_ok ? ST_CLOSE : ST_RES;
				ST_CLOSE: state_q <= sts.cur_is_goal ? ST_RES : ST_NRD;
				ST_NRD: begin
					if (sts.nbr_ok) state_q <= ST_NWR;
					else if (sts.dir_last) state_q <= ST_SINIT;
				end
				ST_NWR: state_q <= sts.dir_last ? ST_SINIT : ST_NRD;
				ST_SINIT: state_q <= ST_SCAN;
				ST_SCAN: if (sts.scan_last) state_q <= ST_SDRAIN;
				ST_SDRAIN: state_q <= ST_SPICK;
				ST_SPICK: state_q <= sts.found ? ST_CLOSE : ST_RES;
				ST_PRD0: state_q <= sts.path_ready ? ST_PRD1 : ST_RES;
				ST_PRD1: state_q <= ST_PRD2;
				ST_PRD2: state_q <= ST_RES;
				ST_RES: if (sts.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/gdp_dp.sv
`timescale 1ns / 1ps

module gdp_dp #(
	parameter int GRID_WIDTH  = 32,
	parameter int GRID_HEIGHT = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gdp_pkg::cmd_t cmd,
	output gdp_pkg::sts_t sts,
	input  logic [31:0]   s_axis_tdata,
	input  logic [1:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [31:0]   m_axis_tdata,
	output logic [1:0]    m_axis_tuser,
	output logic          m_axis_tlast
);

	localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
	localparam int XW    = $clog2(GRID_WIDTH);
	localparam int YW    = $clog2(GRID_HEIGHT);
	localparam int IW    = $clog2(CELLS);
	localparam logic [XW-1:0] X_LAST = XW'(GRID_WIDTH - 1);
	localparam logic [YW-1:0] Y_LAST = YW'(GRID_HEIGHT - 1);
	localparam logic [IW-1:0] I_LAST = IW'(CELLS - 1);

	function automatic logic [IW-1:0] idx_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
		return IW'(int'(y) * GRID_WIDTH + int'(x));
	endfunction

	// Search store and map
	logic              walk_mem   [CELLS];
	logic              closed_mem [CELLS];
	logic [15:0]       cost_mem   [CELLS];
	logic [XW+YW-1:0]  par_mem    [CELLS];

	logic              walk_rd;
	logic              closed_rd;
	logic [15:0]       cost_rd;
	logic [XW+YW-1:0]  par_rd;

	// Latched item
	logic [4:0]  cell_x_q, cell_y_q, st_xi_q, st_yi_q, gl_xi_q, gl_yi_q;
	logic        walkable_q;

	logic [IW-1:0]   cnt_q;
	logic [XW-1:0]   cur_x_q, sc_x_q, best_x_q, cursor_x_q, par_x_q;
	logic [YW-1:0]   cur_y_q, sc_y_q, best_y_q, cursor_y_q, par_y_q;
	logic [15:0]     cur_cost_q, best_q;
	logic            found_q, path_ready_q;
	logic [2:0]      dir_q;
	logic            scan_v_s1;
	logic [XW-1:0]   scan_x_s1;
	logic [YW-1:0]   scan_y_s1;

	logic [1:0]  res_kind_q;
	logic [15:0] res_cost_q;
	logic [4:0]  res_x_q, res_y_q;
	logic        res_last_q;

	logic [XW-1:0] st_x, gl_x, nx;
	logic [YW-1:0] st_y, gl_y, ny;
	logic          map_ok, search_ok, nbr_ok;
	gdp_pkg::step_t stp;
	logic [16:0]   sum17;
	logic [15:0]   new_cost;
	logic          relax_ok, cand, last_hop;
	logic [IW-1:0] rd_idx, nbr_idx;

	assign st_x = XW'(st_xi_q);
	assign st_y = YW'(st_yi_q);
	assign gl_x = XW'(gl_xi_q);
	assign gl_y = YW'(gl_yi_q);
	assign map_ok = (int'(cell_x_q) < GRID_WIDTH) && (int'(cell_y_q) < GRID_HEIGHT);
	assign search_ok = (int'(st_xi_q) < GRID_WIDTH) && (int'(st_yi_q) < GRID_HEIGHT) &&
	                   (int'(gl_xi_q) < GRID_WIDTH) && (int'(gl_yi_q) < GRID_HEIGHT);

	// Neighbor of the current cell
	always_comb begin
		stp = gdp_pkg::nbr_step(dir_q);
		nbr_ok = 1'b1;
		nx = cur_x_q;
		ny = cur_y_q;
		case (stp.dx)
			gdp_pkg::D_INC: begin
				nbr_ok = (cur_x_q != X_LAST);
				nx = cur_x_q + XW'(1);
			end
			gdp_pkg::D_DEC: begin
				if (cur_x_q == '0) nbr_ok = 1'b0;
				nx = cur_x_q - XW'(1);
			end
			default: ;
		endcase
		case (stp.dy)
			gdp_pkg::D_INC: begin
				if (cur_y_q == Y_LAST) nbr_ok = 1'b0;
				ny = cur_y_q + YW'(1);
			end
			gdp_pkg::D_DEC: begin
				if (cur_y_q == '0) nbr_ok = 1'b0;
				ny = cur_y_q - YW'(1);
			end
			default: ;
		endcase
	end

	assign nbr_idx = idx_of(nx, ny);

	// Relaxation with saturation
	assign sum17 = {1'b0, cur_cost_q} + {1'b0,
	               ((stp.dx != gdp_pkg::D_ZERO) && (stp.dy != gdp_pkg::D_ZERO)) ?
	               gdp_pkg::STEP_DIAGONAL : gdp_pkg::STEP_STRAIGHT};
	assign new_cost = (sum17 > {1'b0, gdp_pkg::COST_MAX}) ? gdp_pkg::COST_MAX : sum17[15:0];
	assign relax_ok = walk_rd && !closed_rd && (new_cost < cost_rd);

	// Scan candidate
	assign cand = scan_v_s1 && walk_rd && !closed_rd && (cost_rd < best_q);

	assign last_hop = (cost_rd == '0) || ({par_y_q, par_x_q} == {cursor_y_q, cursor_x_q});

	// Read address
	always_comb begin
		case (cmd.rd_sel)
			gdp_pkg::RD_NBR:  rd_idx = nbr_idx;
			gdp_pkg::RD_SCAN: rd_idx = idx_of(sc_x_q, sc_y_q);
			gdp_pkg::RD_PAR:  rd_idx = idx_of(cursor_x_q, cursor_y_q);
			default:          rd_idx = idx_of(par_rd[XW-1:0], par_rd[XW+YW-1:XW]);
		endcase
	end

	// Memories
	always_ff @(posedge clk) begin
		if (cmd.wipe_wr) walk_mem[cnt_q] <= 1'b0;
		else if (cmd.map_wr && map_ok)
			walk_mem[idx_of(XW'(cell_x_q), YW'(cell_y_q))] <= walkable_q;
		walk_rd <= walk_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) closed_mem[cnt_q] <= 1'b0;
		else if (cmd.close_wr) closed_mem[idx_of(cur_x_q, cur_y_q)] <= 1'b1;
		closed_rd <= closed_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) cost_mem[cnt_q] <= gdp_pkg::COST_UNREACHED;
		else if (cmd.init_start) cost_mem[idx_of(st_x, st_y)] <= '0;
		else if (cmd.relax_wr && relax_ok) cost_mem[nbr_idx] <= new_cost;
		cost_rd <= cost_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.relax_wr && relax_ok) par_mem[nbr_idx] <= {cur_y_q, cur_x_q};
		par_rd <= par_mem[rd_idx];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cell_x_q   <= s_axis_tdata[4:0];
			cell_y_q   <= s_axis_tdata[9:5];
			walkable_q <= s_axis_tdata[10];
			st_xi_q    <= s_axis_tdata[15:11];
			st_yi_q    <= s_axis_tdata[20:16];
			gl_xi_q    <= s_axis_tdata[25:21];
			gl_yi_q    <= s_axis_tdata[30:26];
		end
		if (cmd.init_start) begin
			cur_x_q    <= st_x;
			cur_y_q    <= st_y;
			cur_cost_q <= '0;
		end else if (cmd.pick) begin
			cur_x_q    <= best_x_q;
			cur_y_q    <= best_y_q;
			cur_cost_q <= best_q;
		end
		scan_x_s1 <= sc_x_q;
		scan_y_s1 <= sc_y_q;
		if (cmd.scan_init) begin
			best_q <= gdp_pkg::COST_UNREACHED;
		end else if (cand) begin
			best_q   <= cost_rd;
			best_x_q <= scan_x_s1;
			best_y_q <= scan_y_s1;
		end
		if (cmd.par_latch) begin
			par_x_q <= par_rd[XW-1:0];
			par_y_q <= par_rd[XW+YW-1:XW];
		end
		case (cmd.res_sel)
			gdp_pkg::RES_FOUND: begin
				res_kind_q <= gdp_pkg::REPLY_FOUND;
				res_cost_q <= cur_cost_q;
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_last_q <= 1'b0;
			end
			gdp_pkg::RES_UNREACH: begin
				res_kind_q <= gdp_pkg::REPLY_UNREACH;
				res_cost_q <= gdp_pkg::COST_UNREACHED;
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_last_q <= 1'b0;
			end
			gdp_pkg::RES_PATH_CELL: begin
				res_kind_q <= gdp_pkg::REPLY_PATH_CELL;
				res_cost_q <= '0;
				res_x_q    <= 5'(cursor_x_q);
				res_y_q    <= 5'(cursor_y_q);
				res_last_q <= last_hop;
			end
			gdp_pkg::RES_EXHAUSTED: begin
				res_kind_q <= gdp_pkg::REPLY_EXHAUSTED;
				res_cost_q <= '0;
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_last_q <= 1'b0;
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			m_axis_tdata <= {6'b0, res_y_q, res_x_q, res_cost_q};
			m_axis_tuser <= res_kind_q;
			m_axis_tlast <= res_last_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			dir_q         <= '0;
			sc_x_q        <= '0;
			sc_y_q        <= '0;
			scan_v_s1     <= 1'b0;
			found_q       <= 1'b0;
			path_ready_q  <= 1'b0;
			cursor_x_q    <= '0;
			cursor_y_q    <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_step) cnt_q <= (cnt_q == I_LAST) ? '0 : cnt_q + IW'(1);

			if (cmd.dir_rst) dir_q <= '0;
			else if (cmd.dir_step) dir_q <= dir_q + 3'd1;

			// Column-major sweep, rows inner
			if (cmd.scan_init) begin
				sc_x_q <= '0;
				sc_y_q <= '0;
			end else if (cmd.scan_step) begin
				if (sc_y_q == Y_LAST) begin
					sc_y_q <= '0;
					sc_x_q <= sc_x_q + XW'(1);
				end else begin
					sc_y_q <= sc_y_q + YW'(1);
				end
			end
			scan_v_s1 <= cmd.scan_step;

			if (cmd.scan_init) found_q <= 1'b0;
			else if (cand) found_q <= 1'b1;

			// Pending path
			if (cmd.load_in && (s_axis_tuser == gdp_pkg::FUNC_SEARCH)) begin
				path_ready_q <= 1'b0;
			end else if (cmd.res_sel == gdp_pkg::RES_FOUND) begin
				path_ready_q <= ({cur_y_q, cur_x_q} != {st_y, st_x});
				cursor_x_q   <= cur_x_q;
				cursor_y_q   <= cur_y_q;
			end else if (cmd.res_sel == gdp_pkg::RES_PATH_CELL) begin
				cursor_x_q <= par_x_q;
				cursor_y_q <= par_y_q;
				if (last_hop) path_ready_q <= 1'b0;
			end

			if (cmd.out_load) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
		end
	end

	assign sts.cnt_last    = (cnt_q == I_LAST);
	assign sts.search_ok   = search_ok;
	assign sts.cur_is_goal = ({cur_y_q, cur_x_q} == {gl_y, gl_x});
	assign sts.nbr_ok      = nbr_ok;
	assign sts.dir_last    = (dir_q == 3'(gdp_pkg::NUM_DIRS - 1));
	assign sts.scan_last   = (sc_x_q == X_LAST) && (sc_y_q == Y_LAST);
	assign sts.found       = found_q;
	assign sts.path_ready  = path_ready_q;
	assign sts.out_free    = !m_axis_tvalid || m_axis_tready;

endmodule

### hw/rtl/grid_dijkstra_path_finder.sv
`timescale 1ns / 1ps
// Map write: one cell is written from the latched item. Path read: the cursor's parent
// is read, then the parent's cost, and the reply is staged for the output handoff.
// Search: a pass over all W*H cells clears the search store, then each closed cell
// gets neighbor relaxation plus a least-cost scan over all W*H cells (one memory
// read port per cycle); one item at a time. Reset: asynchronous, active low; after it
// a pass over all W*H cells clears the map to blocked, during which no item is accepted.
module grid_dijkstra_path_finder #(
	parameter int GRID_WIDTH  = 32,
	parameter int GRID_HEIGHT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cell_x, cell_y, walkable, start_x, start_y, goal_x, goal_y
	input  logic [31:0] s_axis_tdata,
	// func
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// path_cost, path_x, path_y
	output logic [31:0] m_axis_tdata,
	// reply_kind
	output logic [1:0]  m_axis_tuser,
	// last_cell
	output logic        m_axis_tlast
);

	gdp_pkg::cmd_t cmd;
	gdp_pkg::sts_t sts;

	gdp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	gdp_dp #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int GW = 32;
	localparam int GH = 32;
	localparam int NCELL = GW * GH;
	localparam int N_ITEMS = 580;
	localparam int WATCHDOG_LIMIT = 120000;

	typedef struct {
		gdp_pkg::reply_t kind;
		logic [15:0]     cost;
		logic [4:0]      px;
		logic [4:0]      py;
		logic            last;
	} reply_rec_t;

	typedef struct {
		gdp_pkg::func_t fn;
		logic [31:0]    data;
		bit             typed;
		reply_rec_t     want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	grid_dijkstra_path_finder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// Shadow of the grid and search store
	bit          walk_sh [NCELL];
	bit          closed_sh [NCELL];
	logic [15:0] cost_sh [NCELL];
	logic [9:0]  parent_sh [NCELL];
	logic [9:0]  cursor_sh;
	bit          ready_sh;

	reply_rec_t  replies_due[$];
	dir_row_t    dir_rows[$];
	int          errs = 0;
	int          n_sent;
	int          n_search;
	int          n_found;
	int          n_cells;
	int          n_recv = 0;
	bit          quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] pack_item(input int cx, input int cy, input int w,
			input int sx, input int sy, input int gx, input int gy);
		logic [4:0] a, b, c, d, e, f;
		a = 5'(cx); b = 5'(cy); c = 5'(sx); d = 5'(sy); e = 5'(gx); f = 5'(gy);
		return {1'b0, f, e, d, c, w[0], b, a};
	endfunction

	// Lower a neighbor's cost through the current cell
	function automatic void relax_nbr(input int cx, input int cy, input int dx, input int dy);
		int nx, ny, n, cur, c;
		nx = cx + dx;
		ny = cy + dy;
		if (nx < 0 || ny < 0 || nx >= GW || ny >= GH)
			return;
		n = ny * GW + nx;
		if (!walk_sh[n] || closed_sh[n])
			return;
		cur = cy * GW + cx;
		c = int'(cost_sh[cur]) + ((dx != 0 && dy != 0) ?
			int'(gdp_pkg::STEP_DIAGONAL) : int'(gdp_pkg::STEP_STRAIGHT));
		if (c > int'(gdp_pkg::COST_MAX))
			c = int'(gdp_pkg::COST_MAX);
		if (c < int'(cost_sh[n])) begin
			cost_sh[n] = 16'(c);
			parent_sh[n] = 10'(cur);
		end
	endfunction

	// Dijkstra with full least-cost scan; 1 when the goal is closed
	function automatic bit shortest_path(input int sx, input int sy, input int gx, input int gy);
		int cx, cy, goal, best, bx, by, k;
		for (int i = 0; i < NCELL; i++) begin
			closed_sh[i] = 0;
			cost_sh[i] = gdp_pkg::COST_UNREACHED;
			parent_sh[i] = '0;
		end
		goal = gy * GW + gx;
		cx = sx;
		cy = sy;
		cost_sh[sy * GW + sx] = '0;
		while (!closed_sh[goal]) begin
			closed_sh[cy * GW + cx] = 1;
			if (closed_sh[goal])
				break;
			relax_nbr(cx, cy, 1, 0);
			relax_nbr(cx, cy, 1, 1);
			relax_nbr(cx, cy, 0, 1);
			relax_nbr(cx, cy, -1, 1);
			relax_nbr(cx, cy, -1, 0);
			relax_nbr(cx, cy, -1, -1);
			relax_nbr(cx, cy, 0, -1);
			relax_nbr(cx, cy, 1, -1);
			best = int'(gdp_pkg::COST_UNREACHED);
			bx = -1;
			by = -1;
			for (int x = 0; x < GW; x++)
				for (int y = 0; y < GH; y++) begin
					k = y * GW + x;
					if (walk_sh[k] && !closed_sh[k] && int'(cost_sh[k]) < best) begin
						best = int'(cost_sh[k]);
						bx = x;
						by = y;
					end
				end
			if (bx < 0)
				return 0;
			cx = bx;
			cy = by;
			closed_sh[cy * GW + cx] = 1;
		end
		return 1;
	endfunction

	// Advance the shadow by one item; 1 when a reply is due
	function automatic bit predict_reply(input gdp_pkg::func_t fn, input logic [31:0] d,
			output reply_rec_t r);
		int sx, sy, gx, gy, cur, par;
		r = '{kind: gdp_pkg::REPLY_FOUND, cost: '0, px: '0, py: '0, last: 1'b0};
		case (fn)
			gdp_pkg::FUNC_MAP_WRITE: begin
				walk_sh[int'(d[9:5]) * GW + int'(d[4:0])] = d[10];
				return 0;
			end
			gdp_pkg::FUNC_SEARCH: begin
				sx = int'(d[15:11]); sy = int'(d[20:16]);
				gx = int'(d[25:21]); gy = int'(d[30:26]);
				ready_sh = 0;
				n_search++;
				if (shortest_path(sx, sy, gx, gy)) begin
					r.kind = gdp_pkg::REPLY_FOUND;
					r.cost = cost_sh[gy * GW + gx];
					n_found++;
					if (sx != gx || sy != gy) begin
						cursor_sh = 10'(gy * GW + gx);
						ready_sh = 1;
					end
				end else begin
					r.kind = gdp_pkg::REPLY_UNREACH;
					r.cost = gdp_pkg::COST_UNREACHED;
				end
				return 1;
			end
			gdp_pkg::FUNC_PATH_READ: begin
				if (!ready_sh) begin
					r.kind = gdp_pkg::REPLY_EXHAUSTED;
					return 1;
				end
				cur = int'(cursor_sh);
				par = int'(parent_sh[cur]);
				r.kind = gdp_pkg::REPLY_PATH_CELL;
				r.px = 5'(cur % GW);
				r.py = 5'(cur / GW);
				n_cells++;
				if (cost_sh[par] == '0 || par == cur) begin
					r.last = 1'b1;
					ready_sh = 0;
				end
				cursor_sh = 10'(par);
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	// Present one item, wait for it to be taken, record what it should produce
	task automatic send_item(input gdp_pkg::func_t fn, input logic [31:0] d, input bit typed,
			input reply_rec_t want);
		int gap;
		reply_rec_t r;
		bit due;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = int'($urandom_range(1, 11));
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= fn;
		do @(posedge clk); while (!s_axis_tready);
		due = predict_reply(fn, d, r);
		if (due)
			replies_due.push_back(typed ? want : r);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic send_pred(input gdp_pkg::func_t fn, input logic [31:0] d);
		reply_rec_t none;
		none = '{kind: gdp_pkg::REPLY_FOUND, cost: '0, px: '0, py: '0, last: 1'b0};
		send_item(fn, d, 1'b0, none);
	endtask

	task automatic add_row(input gdp_pkg::func_t fn, input logic [31:0] d, input bit typed,
			input gdp_pkg::reply_t k, input int c, input int px, input int py, input bit last);
		dir_row_t row;
		row.fn = fn;
		row.data = d;
		row.typed = typed;
		row.want = '{kind: k, cost: 16'(c), px: 5'(px), py: 5'(py), last: last};
		dir_rows.push_back(row);
	endtask

	// Receiver backpressure in bursts
	int stall_left = 0;
	always @(negedge clk) begin
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= int'($urandom_range(0, 10));
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Reply checker
	always @(posedge clk) begin
		reply_rec_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_recv++;
			if (replies_due.size() == 0) begin
				$error("unexpected reply kind=%0d data=%h", m_axis_tuser, m_axis_tdata);
				errs++;
			end else begin
				w = replies_due.pop_front();
				if (m_axis_tuser !== w.kind) begin
					$error("reply_kind: expected %0d, got %0d", w.kind, m_axis_tuser);
					errs++;
				end
				if (m_axis_tdata[15:0] !== w.cost) begin
					$error("path_cost: expected %0d, got %0d", w.cost, m_axis_tdata[15:0]);
					errs++;
				end
				if (m_axis_tdata[20:16] !== w.px) begin
					$error("path_x: expected %0d, got %0d", w.px, m_axis_tdata[20:16]);
					errs++;
				end
				if (m_axis_tdata[25:21] !== w.py) begin
					$error("path_y: expected %0d, got %0d", w.py, m_axis_tdata[25:21]);
					errs++;
				end
				if (m_axis_tdata[31:26] !== 6'd0) begin
					$error("tdata pad: expected 0, got %0d", m_axis_tdata[31:26]);
					errs++;
				end
				if (m_axis_tlast !== w.last) begin
					$error("last_cell: expected %0d, got %0d", w.last, m_axis_tlast);
					errs++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either side
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("timeout: %0d replies still due", replies_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int ox, oy, bw, bh, n_srch, n_rd, ep;
		int sx, sy, gx, gy;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = gdp_pkg::FUNC_MAP_WRITE;
		n_sent = 0; n_search = 0; n_found = 0; n_cells = 0;
		quiet = 0;
		for (int i = 0; i < NCELL; i++) begin
			walk_sh[i] = 0;
			closed_sh[i] = 0;
			cost_sh[i] = gdp_pkg::COST_UNREACHED;
			parent_sh[i] = '0;
		end
		cursor_sh = '0;
		ready_sh = 0;

		// Directed rows
		add_row(gdp_pkg::FUNC_PATH_READ, '0, 1, gdp_pkg::REPLY_EXHAUSTED, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_SEARCH, pack_item(0, 0, 0, 0, 0, 31, 31), 1,
			gdp_pkg::REPLY_UNREACH, int'(gdp_pkg::COST_UNREACHED), 0, 0, 0);
		add_row(gdp_pkg::FUNC_UNUSED, 32'h7FFF_FFFF, 0, gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(0, 0, 1, 0, 0, 0, 0), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(1, 1, 1, 31, 31, 31, 31), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(31, 31, 1, 0, 0, 0, 0), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(30, 31, 1, 0, 0, 0, 0), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(31, 30, 1, 0, 0, 0, 0), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		// start equal to goal: found at cost 0, no path
		add_row(gdp_pkg::FUNC_SEARCH, pack_item(0, 0, 0, 0, 0, 0, 0), 1,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_PATH_READ, '0, 1, gdp_pkg::REPLY_EXHAUSTED, 0, 0, 0, 0);
		// one diagonal step
		add_row(gdp_pkg::FUNC_SEARCH, pack_item(0, 0, 0, 0, 0, 1, 1), 1,
			gdp_pkg::REPLY_FOUND, 14, 0, 0, 0);
		add_row(gdp_pkg::FUNC_PATH_READ, '0, 1, gdp_pkg::REPLY_PATH_CELL, 0, 1, 1, 1);
		add_row(gdp_pkg::FUNC_PATH_READ, '0, 1, gdp_pkg::REPLY_EXHAUSTED, 0, 0, 0, 0);
		// blocked goal
		add_row(gdp_pkg::FUNC_SEARCH, pack_item(0, 0, 0, 31, 31, 30, 30), 1,
			gdp_pkg::REPLY_UNREACH, int'(gdp_pkg::COST_UNREACHED), 0, 0, 0);
		add_row(gdp_pkg::FUNC_SEARCH, pack_item(0, 0, 0, 30, 31, 31, 30), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		// map write leaves the pending path readable
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(30, 30, 0, 0, 0, 0, 0), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_PATH_READ, '0, 0, gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_PATH_READ, '0, 0, gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		// blocked start still relaxes its neighbors
		add_row(gdp_pkg::FUNC_SEARCH, pack_item(0, 0, 0, 1, 0, 1, 1), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_PATH_READ, '0, 0, gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_PATH_READ, '0, 0, gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(31, 31, 0, 0, 0, 0, 0), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(30, 31, 0, 0, 0, 0, 0), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(31, 30, 0, 0, 0, 0, 0), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(1, 1, 0, 0, 0, 0, 0), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);
		add_row(gdp_pkg::FUNC_MAP_WRITE, pack_item(0, 0, 0, 0, 0, 0, 0), 0,
			gdp_pkg::REPLY_FOUND, 0, 0, 0, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].fn, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);

		// Random episodes: small mostly walkable patch, searches starting inside it, path walks, cleanup
		ep = 0;
		while (n_sent < N_ITEMS) begin
			if (n_sent > N_ITEMS - 100)
				quiet = 1;
			bw = int'($urandom_range(2, 5));
			bh = int'($urandom_range(2, 5));
			ox = int'($urandom_range(0, GW - bw));
			oy = int'($urandom_range(0, GH - bh));
			for (int y = 0; y < bh; y++)
				for (int x = 0; x < bw; x++)
					send_pred(gdp_pkg::FUNC_MAP_WRITE, pack_item(ox + x, oy + y,
						int'($urandom_range(0, 3) != 0), $urandom, $urandom,
						$urandom, $urandom));
			n_srch = int'($urandom_range(1, 3));
			for (int s = 0; s < n_srch; s++) begin
				sx = ox + int'($urandom_range(0, bw - 1));
				sy = oy + int'($urandom_range(0, bh - 1));
				gx = ox + int'($urandom_range(0, bw - 1));
				gy = oy + int'($urandom_range(0, bh - 1));
				if ($urandom_range(0, 7) == 0) begin
					gx = int'($urandom_range(0, 31));
					gy = int'($urandom_range(0, 31));
				end
				send_pred(gdp_pkg::FUNC_SEARCH,
					pack_item($urandom, $urandom, $urandom, sx, sy, gx, gy));
				n_rd = int'($urandom_range(0, 12));
				for (int r = 0; r < n_rd; r++) begin
					case ($urandom_range(0, 9))
						0: send_pred(gdp_pkg::FUNC_UNUSED, $urandom);
						1: send_pred(gdp_pkg::FUNC_MAP_WRITE, pack_item($urandom, $urandom, 0,
							$urandom, $urandom, $urandom, $urandom));
						default: send_pred(gdp_pkg::FUNC_PATH_READ, $urandom);
					endcase
				end
			end
			for (int y = 0; y < bh; y++)
				for (int x = 0; x < bw; x++)
					send_pred(gdp_pkg::FUNC_MAP_WRITE, pack_item(ox + x, oy + y, 0,
						$urandom, $urandom, $urandom, $urandom));
			ep++;
			// after the fourth episode, hold off until every reply has drained
			if (ep == 4) begin
				s_axis_tvalid <= 1'b0;
				while (replies_due.size() != 0)
					@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d items in %0d patch episodes; %0d searches (%0d found),",
			n_sent, ep, n_search, n_found);
		$display("%0d path cells walked, %0d replies checked, %0d errors", n_cells, n_recv, errs);
		if (errs == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
